>>> sv/mgr_pkg.sv
`default_nettype none
package mgr_pkg;

  localparam int MAX_CHANNELS    = 32;
  localparam int MAX_RAMPERS     = 8;
  localparam int SAMPLE_BITS     = 24;
  localparam int EXP_TABLE_DEPTH = 64;

  localparam int DB_W       = 14;
  localparam int FINE_SHIFT = 8;
  localparam int FINE_W     = 22;
  localparam int LIN_W      = 24;
  localparam int RAMP_W     = 16;
  localparam int CH_W       = 5;

  localparam logic signed [DB_W-1:0] DB_MIN = -14'sd6144;
  localparam logic signed [DB_W-1:0] DB_MAX = 14'sd1536;
  localparam logic [16:0]            OCT_K  = 17'd43541;
  localparam logic [63:0]            LN2_Q30 = 64'd744261118;
  localparam logic [63:0]            ONE_Q30 = 64'd1073741824;
  localparam logic [LIN_W-1:0]       LIN_MAX = 24'hFFFFFF;
  localparam logic [3:0]             BYPASS_CODE = 4'd15;

  // Configuration reset values.
  localparam logic [5:0]             RST_NUM_CHANNELS = 6'd2;
  localparam logic [3:0]             RST_NUM_RAMPERS  = 4'd1;
  localparam logic [RAMP_W-1:0]      RST_RAMP_BLOCKS  = 16'd45;
  localparam logic signed [DB_W-1:0] RST_FLOOR_DB     = -14'sd6144;
  localparam logic signed [DB_W-1:0] RST_INITIAL_DB   = 14'sd0;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_TARGET = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    CFG_NUM_CHANNELS = 3'd0,
    CFG_NUM_RAMPERS  = 3'd1,
    CFG_RAMP_BLOCKS  = 3'd2,
    CFG_FLOOR_DB     = 3'd3,
    CFG_INITIAL_DB   = 3'd4,
    CFG_MAP_LOW      = 3'd5,
    CFG_MAP_HIGH     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOAD_LIN,
    ST_LOAD_WAIT,
    ST_LOAD_WR,
    ST_IDLE,
    ST_SMP_RD,
    ST_SMP_MUL,
    ST_SMP_RND,
    ST_SL_RD,
    ST_SL_EXE,
    ST_SL_DIV,
    ST_SL_LIN,
    ST_SL_WR
  } state_e;

  // One ramper slot as kept in the state memory.
  typedef struct packed {
    logic signed [FINE_W-1:0] cur;
    logic signed [DB_W-1:0]   tgt;
    logic signed [FINE_W-1:0] step;
    logic [LIN_W-1:0]         lin;
  } slot_t;

endpackage
`default_nettype wire

>>> sv/mgr_ram.sv
`default_nettype none
module mgr_ram #(
  parameter int Width = 8,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> sv/mgr_div.sv
`default_nettype none
// Signed dividend over unsigned divisor, quotient truncated toward zero.
// Restoring division, one quotient bit per cycle.
module mgr_div (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic signed [mgr_pkg::FINE_W-1:0]  dividend_i,
  input  wire logic        [mgr_pkg::RAMP_W-1:0]  divisor_i,
  output logic                                    done_o,
  output logic signed      [mgr_pkg::FINE_W-1:0]  quotient_o
);
  localparam int W    = mgr_pkg::FINE_W;
  localparam int DW   = mgr_pkg::RAMP_W;
  localparam int CntW = $clog2(W + 1);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    num_q;
  logic [DW-1:0]   rem_q;
  logic [DW-1:0]   den_q;
  logic            neg_q;
  logic            done_q;
  logic [W-1:0]    quo_q;

  logic [DW:0]     rem_sh;
  logic            fits;
  logic [W-1:0]    num_nxt;

  always_comb begin
    rem_sh  = {rem_q, num_q[W-1]};
    fits    = rem_sh >= {1'b0, den_q};
    num_nxt = {num_q[W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i[W-1] ? (W'(0) - dividend_i) : dividend_i;
      neg_q <= dividend_i[W-1];
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_nxt;
      rem_q <= fits ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
      if (cnt_q == CntW'(W - 1)) begin
        quo_q <= neg_q ? (W'(0) - num_nxt) : num_nxt;
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

>>> sv/mgr_lin.sv
`default_nettype none
// Fine dB (1/16384 dB) to linear Q4.20 gain, four pipeline stages:
// octave multiply, table lookup, interpolation, shift and round.
module mgr_lin #(
  parameter int EXP_TABLE_DEPTH = mgr_pkg::EXP_TABLE_DEPTH
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic signed [mgr_pkg::FINE_W-1:0]  in_db_i,
  output logic                                    out_valid_o,
  output logic             [mgr_pkg::LIN_W-1:0]   out_lin_o
);
  localparam int W    = mgr_pkg::FINE_W;
  localparam int IdxW = $clog2(EXP_TABLE_DEPTH);
  localparam int PosW = 16 + $clog2(EXP_TABLE_DEPTH + 1);

  // Entry i holds 2^(i/depth) in Q30 from a truncated series for e^z.
  function automatic logic [31:0] exp_calc(input int unsigned idx);
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    z    = (64'(idx) * mgr_pkg::LN2_Q30) / 64'(EXP_TABLE_DEPTH);
    term = mgr_pkg::ONE_Q30;
    sum  = mgr_pkg::ONE_Q30;
    for (int unsigned k = 1; k <= 12; k++) begin
      term = ((term * z) >> 30) / 64'(k);
      sum  = sum + term;
    end
    return sum[31:0];
  endfunction

  logic [31:0] tab [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [31:0] Val = exp_calc(g);
    assign tab[g] = Val;
  end

  logic [3:0] vld_q;

  // Stage 1: octaves in Q16, floored.
  logic signed [W+17:0] oct_prod;
  logic signed [22:0]   x_q;
  assign oct_prod = in_db_i * $signed({1'b0, mgr_pkg::OCT_K});

  // Stage 2: table lookup.
  logic signed [6:0] n_x;
  logic [PosW-1:0]   pos;
  logic [IdxW-1:0]   idx;
  logic [31:0]       tab_a;
  logic [31:0]       tab_b;
  logic [31:0]       a_q;
  logic [31:0]       dd_q;
  logic [15:0]       r_q;
  logic signed [6:0] n2_q;

  always_comb begin
    n_x   = x_q[22:16];
    pos   = PosW'(x_q[15:0]) * PosW'(EXP_TABLE_DEPTH);
    idx   = pos[16 +: IdxW];
    tab_a = tab[idx];
    tab_b = (idx == IdxW'(EXP_TABLE_DEPTH - 1)) ? 32'h8000_0000 : tab[IdxW'(idx + IdxW'(1))];
  end

  // Stage 3: interpolation.
  logic [47:0]       interp;
  logic [31:0]       v_q;
  logic signed [6:0] n3_q;
  assign interp = dd_q * {32'd0, r_q};

  // Stage 4: shift to Q20, round half up, saturate.
  logic signed [7:0] sh;
  logic [41:0]       rsum;
  logic [41:0]       rshift;
  logic [23:0]       lin_d;
  logic [23:0]       lin_q;

  always_comb begin
    sh     = 8'sd10 - {n3_q[6], n3_q};
    rsum   = {10'd0, v_q} + (42'd1 << (sh[5:0] - 6'd1));
    rshift = rsum >> sh[5:0];
    if (sh > 8'sd40) begin
      lin_d = '0;
    end else if (sh < 8'sd1) begin
      lin_d = mgr_pkg::LIN_MAX;
    end else if (rshift > {18'd0, mgr_pkg::LIN_MAX}) begin
      lin_d = mgr_pkg::LIN_MAX;
    end else begin
      lin_d = rshift[23:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= oct_prod[38:16];
    a_q   <= tab_a;
    dd_q  <= tab_b - tab_a;
    r_q   <= pos[15:0];
    n2_q  <= n_x;
    v_q   <= a_q + interp[47:16];
    n3_q  <= n2_q;
    lin_q <= lin_d;
  end

  assign out_valid_o = vld_q[3];
  assign out_lin_o   = lin_q;
endmodule
`default_nettype wire

>>> sv/multichannel_gain_ramper_core.sv
// Multichannel gain ramper. Up to MAX_RAMPERS slots each keep a current gain, a
// target gain and a per-tick step in dB, plus the matching linear gain, all in one
// slot memory. tuser selects the item kind: an audio sample, a block tick or a new
// target gain. A sample passes acceptance, memory read, multiply and round on its
// way to the result register and yields one output item; channels beyond
// num_channels or mapped to code 15 pass at unity. Ticks and target sets yield
// no output and walk the active slots one at a time through the memory: a tick
// or an immediate jump takes each slot through the 4-stage dB to linear
// pipeline, a ramped target through the divider instead. After reset, and after
// every initial_db write, a load pass converts the initial gain once and writes
// it into all slots; no item and no configuration write is taken meanwhile. The
// output register lets the next item enter while a result still waits
// downstream.
`default_nettype none
module multichannel_gain_ramper_core #(
  parameter int MAX_CHANNELS    = mgr_pkg::MAX_CHANNELS,
  parameter int MAX_RAMPERS     = mgr_pkg::MAX_RAMPERS,
  parameter int SAMPLE_BITS     = mgr_pkg::SAMPLE_BITS,
  parameter int EXP_TABLE_DEPTH = mgr_pkg::EXP_TABLE_DEPTH,
  localparam int InW  = ((mgr_pkg::CH_W + SAMPLE_BITS + mgr_pkg::DB_W + 7) / 8) * 8,
  localparam int OutW = ((SAMPLE_BITS + mgr_pkg::CH_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel[4:0], sample_in, target_db, zero fill
  input  wire logic [InW-1:0]   s_axis_tdata,
  // req_type
  input  wire logic [1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // sample_out, out_channel, zero fill
  output logic      [OutW-1:0]  m_axis_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [63:0]      cfg_data
);
  localparam int SlotW = (MAX_RAMPERS > 1) ? $clog2(MAX_RAMPERS) : 1;
  localparam int FW    = mgr_pkg::FINE_W;
  localparam int DW    = mgr_pkg::DB_W;
  localparam int PW    = SAMPLE_BITS + 25;
  localparam int YW    = SAMPLE_BITS + 6;

  mgr_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [5:0]                   num_channels_q;
  logic [3:0]                   num_rampers_q;
  logic [mgr_pkg::RAMP_W-1:0]   ramp_blocks_q;
  logic signed [DW-1:0]         floor_db_q;
  logic signed [DW-1:0]         initial_db_q;
  logic [63:0]                  map_low_q;
  logic [63:0]                  map_high_q;

  logic cfg_fire;
  logic in_fire;
  assign cfg_ready     = (state_q == mgr_pkg::ST_IDLE);
  assign s_axis_tready = (state_q == mgr_pkg::ST_IDLE) && !cfg_valid;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= mgr_pkg::RST_NUM_CHANNELS;
      num_rampers_q  <= mgr_pkg::RST_NUM_RAMPERS;
      ramp_blocks_q  <= mgr_pkg::RST_RAMP_BLOCKS;
      floor_db_q     <= mgr_pkg::RST_FLOOR_DB;
      initial_db_q   <= mgr_pkg::RST_INITIAL_DB;
      map_low_q      <= '0;
      map_high_q     <= '0;
    end else if (cfg_fire) begin
      case (mgr_pkg::cfg_idx_e'(cfg_index))
        mgr_pkg::CFG_NUM_CHANNELS: num_channels_q <= cfg_data[5:0];
        mgr_pkg::CFG_NUM_RAMPERS:  num_rampers_q  <= cfg_data[3:0];
        mgr_pkg::CFG_RAMP_BLOCKS:  ramp_blocks_q  <= cfg_data[15:0];
        mgr_pkg::CFG_FLOOR_DB:     floor_db_q     <= cfg_data[13:0];
        mgr_pkg::CFG_INITIAL_DB:   initial_db_q   <= cfg_data[13:0];
        mgr_pkg::CFG_MAP_LOW:      map_low_q      <= cfg_data;
        mgr_pkg::CFG_MAP_HIGH:     map_high_q     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective settings.
  logic [4:0]           nr_eff;
  logic signed [DW-1:0] fl_eff;
  logic signed [FW-1:0] flf;
  logic signed [DW-1:0] init_eff;
  logic signed [FW-1:0] init_fine;

  always_comb begin
    if (num_rampers_q == 4'd0) begin
      nr_eff = 5'd1;
    end else if ({1'b0, num_rampers_q} > 5'(MAX_RAMPERS)) begin
      nr_eff = 5'(MAX_RAMPERS);
    end else begin
      nr_eff = {1'b0, num_rampers_q};
    end
    if (floor_db_q > 14'sd0) begin
      fl_eff = '0;
    end else if (floor_db_q < mgr_pkg::DB_MIN) begin
      fl_eff = mgr_pkg::DB_MIN;
    end else begin
      fl_eff = floor_db_q;
    end
    flf = {fl_eff, 8'd0};
    if (initial_db_q < mgr_pkg::DB_MIN) begin
      init_eff = mgr_pkg::DB_MIN;
    end else if (initial_db_q > mgr_pkg::DB_MAX) begin
      init_eff = mgr_pkg::DB_MAX;
    end else begin
      init_eff = initial_db_q;
    end
    init_fine = {init_eff, 8'd0};
  end

  // Input fields.
  logic [mgr_pkg::CH_W-1:0]      in_ch;
  logic signed [SAMPLE_BITS-1:0] in_smp;
  logic signed [DW-1:0]          in_tgt;
  logic signed [DW-1:0]          tgt_clamp;
  logic signed [DW-1:0]          tgt_eff;
  logic                          ch_used;
  logic [3:0]                    map_code;
  logic                          unity;
  logic [SlotW-1:0]              map_slot;

  always_comb begin
    in_ch  = s_axis_tdata[mgr_pkg::CH_W-1:0];
    in_smp = s_axis_tdata[mgr_pkg::CH_W +: SAMPLE_BITS];
    in_tgt = s_axis_tdata[mgr_pkg::CH_W + SAMPLE_BITS +: DW];
    if (in_tgt < mgr_pkg::DB_MIN) begin
      tgt_clamp = mgr_pkg::DB_MIN;
    end else if (in_tgt > mgr_pkg::DB_MAX) begin
      tgt_clamp = mgr_pkg::DB_MAX;
    end else begin
      tgt_clamp = in_tgt;
    end
    tgt_eff  = (tgt_clamp < fl_eff) ? fl_eff : tgt_clamp;
    ch_used  = ({1'b0, in_ch} < num_channels_q) && ({2'b0, in_ch} < 7'(MAX_CHANNELS));
    map_code = in_ch[4] ? map_high_q[{in_ch[3:0], 2'b00} +: 4]
                        : map_low_q[{in_ch[3:0], 2'b00} +: 4];
    unity    = !ch_used || (map_code == mgr_pkg::BYPASS_CODE);
    map_slot = ({1'b0, map_code} >= nr_eff) ? '0 : SlotW'(map_code);
  end

  // Item registers.
  mgr_pkg::req_e                 op_q;
  logic [mgr_pkg::CH_W-1:0]      ch_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [DW-1:0]          tgt_req_q;
  logic                          unity_q;
  logic [SlotW-1:0]              smp_slot_q;
  logic signed [PW-1:0]          prod_q;

  // Slot walk registers.
  logic [SlotW-1:0]              slot_q, slot_d;
  logic signed [FW-1:0]          cur_q;
  logic signed [DW-1:0]          tgt_q;
  logic signed [FW-1:0]          step_q;
  logic [mgr_pkg::LIN_W-1:0]     lin_q;
  logic                          diff_neg_q;

  // State memory.
  mgr_pkg::slot_t   rd;
  mgr_pkg::slot_t   wr;
  logic             ram_we;
  logic [SlotW-1:0] ram_raddr;

  assign wr        = '{cur: cur_q, tgt: tgt_q, step: step_q, lin: lin_q};
  assign ram_raddr = (state_q == mgr_pkg::ST_SMP_RD) ? smp_slot_q : slot_q;

  mgr_ram #(
    .Width ($bits(mgr_pkg::slot_t)),
    .Depth (MAX_RAMPERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (wr),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  // Slot update math on the entry just read.
  logic signed [FW-1:0] tick_tf;
  logic signed [FW:0]   tick_sum;
  logic                 tick_snap;
  logic signed [FW-1:0] tick_cur;
  logic signed [FW-1:0] tick_step;
  logic signed [FW-1:0] set_tf;
  logic signed [FW-1:0] set_cur;
  logic signed [FW-1:0] set_diff;
  logic                 set_jump;

  always_comb begin
    tick_tf   = {rd.tgt, 8'd0};
    tick_sum  = {rd.cur[FW-1], rd.cur} + {rd.step[FW-1], rd.step};
    tick_snap = (rd.step > 0 && tick_sum >= $signed({tick_tf[FW-1], tick_tf})) ||
                (rd.step < 0 && tick_sum <= $signed({tick_tf[FW-1], tick_tf}));
    tick_cur  = rd.cur;
    tick_step = rd.step;
    if (rd.step != '0) begin
      if (tick_snap) begin
        tick_cur  = tick_tf;
        tick_step = '0;
      end else begin
        tick_cur = tick_sum[FW-1:0];
      end
    end
    if (tick_cur < flf) begin
      tick_cur = flf;
    end
    set_tf   = {tgt_req_q, 8'd0};
    set_cur  = (rd.cur < flf) ? flf : rd.cur;
    set_diff = set_tf - set_cur;
    set_jump = (set_diff == '0) || (ramp_blocks_q == '0);
  end

  // Shared units.
  logic                      lin_start;
  logic signed [FW-1:0]      lin_db;
  logic                      lin_vld;
  logic [mgr_pkg::LIN_W-1:0] lin_out;
  logic                      div_start;
  logic                      div_done;
  logic signed [FW-1:0]      div_quo;

  mgr_lin #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_lin (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (lin_start),
    .in_db_i     (lin_db),
    .out_valid_o (lin_vld),
    .out_lin_o   (lin_out)
  );

  mgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (set_diff),
    .divisor_i  (ramp_blocks_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Output register.
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;
  logic [mgr_pkg::CH_W-1:0]      out_ch_q;
  logic                          out_load;
  logic signed [PW:0]            rnd;
  logic signed [YW-1:0]          y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  always_comb begin
    rnd    = {prod_q[PW-1], prod_q} + (PW+1)'(1 << 19);
    y_full = YW'(rnd >>> 20);
    if (y_full > $signed(YW'({1'b0, {(SAMPLE_BITS-1){1'b1}}}))) begin
      y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (y_full < $signed(YW'({{(YW-SAMPLE_BITS+1){1'b1}},
                                      {(SAMPLE_BITS-1){1'b0}}}))) begin
      y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  logic last_active;
  logic last_slot;
  assign last_active = (5'(slot_q) + 5'd1) == nr_eff;
  assign last_slot   = slot_q == SlotW'(MAX_RAMPERS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mgr_pkg::ST_LOAD_LIN;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    ram_we    = 1'b0;
    lin_start = 1'b0;
    lin_db    = init_fine;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      mgr_pkg::ST_LOAD_LIN: begin
        lin_start = 1'b1;
        state_d   = mgr_pkg::ST_LOAD_WAIT;
      end
      mgr_pkg::ST_LOAD_WAIT: begin
        if (lin_vld) begin
          slot_d  = '0;
          state_d = mgr_pkg::ST_LOAD_WR;
        end
      end
      mgr_pkg::ST_LOAD_WR: begin
        ram_we = 1'b1;
        if (last_slot) begin
          state_d = mgr_pkg::ST_IDLE;
        end else begin
          slot_d = slot_q + SlotW'(1);
        end
      end
      mgr_pkg::ST_IDLE: begin
        if (cfg_fire && mgr_pkg::cfg_idx_e'(cfg_index) == mgr_pkg::CFG_INITIAL_DB) begin
          state_d = mgr_pkg::ST_LOAD_LIN;
        end else if (in_fire) begin
          case (mgr_pkg::req_e'(s_axis_tuser))
            mgr_pkg::REQ_SAMPLE: state_d = mgr_pkg::ST_SMP_RD;
            mgr_pkg::REQ_TICK,
            mgr_pkg::REQ_TARGET: begin
              slot_d  = '0;
              state_d = mgr_pkg::ST_SL_RD;
            end
            default: ;
          endcase
        end
      end
      mgr_pkg::ST_SMP_RD:  state_d = mgr_pkg::ST_SMP_MUL;
      mgr_pkg::ST_SMP_MUL: state_d = mgr_pkg::ST_SMP_RND;
      mgr_pkg::ST_SMP_RND: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = mgr_pkg::ST_IDLE;
        end
      end
      mgr_pkg::ST_SL_RD: state_d = mgr_pkg::ST_SL_EXE;
      mgr_pkg::ST_SL_EXE: begin
        if (op_q == mgr_pkg::REQ_TICK) begin
          lin_start = 1'b1;
          lin_db    = tick_cur;
          state_d   = mgr_pkg::ST_SL_LIN;
        end else if (set_jump) begin
          lin_start = 1'b1;
          lin_db    = set_tf;
          state_d   = mgr_pkg::ST_SL_LIN;
        end else begin
          div_start = 1'b1;
          state_d   = mgr_pkg::ST_SL_DIV;
        end
      end
      mgr_pkg::ST_SL_DIV: begin
        if (div_done) begin
          state_d = mgr_pkg::ST_SL_WR;
        end
      end
      mgr_pkg::ST_SL_LIN: begin
        if (lin_vld) begin
          state_d = mgr_pkg::ST_SL_WR;
        end
      end
      mgr_pkg::ST_SL_WR: begin
        ram_we = 1'b1;
        if (last_active) begin
          state_d = mgr_pkg::ST_IDLE;
        end else begin
          slot_d  = slot_q + SlotW'(1);
          state_d = mgr_pkg::ST_SL_RD;
        end
      end
      default: state_d = mgr_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= mgr_pkg::req_e'(s_axis_tuser);
      ch_q       <= in_ch;
      smp_q      <= in_smp;
      tgt_req_q  <= tgt_eff;
      unity_q    <= unity;
      smp_slot_q <= map_slot;
    end
    if (state_q == mgr_pkg::ST_SMP_MUL) begin
      // Unity gain is 1.0 in Q4.20, which passes the sample through exactly.
      prod_q <= smp_q * $signed(unity_q ? 25'(1 << 20) : {1'b0, rd.lin});
    end
    if (state_q == mgr_pkg::ST_LOAD_LIN) begin
      cur_q  <= init_fine;
      tgt_q  <= init_eff;
      step_q <= '0;
    end
    if (state_q == mgr_pkg::ST_SL_EXE) begin
      lin_q      <= rd.lin;
      diff_neg_q <= set_diff[FW-1];
      if (op_q == mgr_pkg::REQ_TICK) begin
        cur_q  <= tick_cur;
        step_q <= tick_step;
        tgt_q  <= rd.tgt;
      end else begin
        tgt_q <= tgt_req_q;
        if (set_jump) begin
          cur_q  <= set_tf;
          step_q <= '0;
        end else begin
          cur_q <= rd.cur;
        end
      end
    end
    if (lin_vld) begin
      lin_q <= lin_out;
    end
    if (state_q == mgr_pkg::ST_SL_DIV && div_done) begin
      // A quotient that truncates to zero still moves one LSB toward the target.
      if (div_quo == '0) begin
        step_q <= diff_neg_q ? -FW'(1) : FW'(1);
      end else begin
        step_q <= div_quo;
      end
    end
    if (out_load) begin
      out_smp_q <= y_sat;
      out_ch_q  <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_ch_q, out_smp_q});

`ifndef ASSERT_OFF
  a_we_only_in_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == mgr_pkg::ST_LOAD_WR || state_q == mgr_pkg::ST_SL_WR))
    else $error("slot memory written outside a write state");
  a_slot_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mgr_pkg::ST_SL_WR) |-> (5'(slot_q) < nr_eff))
    else $error("slot walk beyond the active slots");
  a_lin_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lin_vld |-> (state_q == mgr_pkg::ST_LOAD_WAIT || state_q == mgr_pkg::ST_SL_LIN))
    else $error("linear gain result arrived unexpectedly");
  a_div_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == mgr_pkg::ST_SL_DIV))
    else $error("divider finished unexpectedly");
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while full");
`endif
endmodule
`default_nettype wire

>>> sim/multichannel_gain_ramper_checker.sv
`default_nettype none
module multichannel_gain_ramper_checker
  import mgr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic [1:0]  s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] smp;
    logic [4:0]  chan;
  } gained_t;

  gained_t gained_q[$];

  longint unsigned pow2_tab[EXP_TABLE_DEPTH];

  logic [5:0]  r_nch;
  logic [3:0]  r_nramp;
  logic [15:0] r_ramp;
  logic [13:0] r_floor;
  logic [13:0] r_init;
  logic [63:0] r_map_lo, r_map_hi;

  int          gain_cur[MAX_RAMPERS];
  int          gain_tgt[MAX_RAMPERS];
  int          gain_step[MAX_RAMPERS];
  int unsigned gain_lin[MAX_RAMPERS];

  assign pending_count = gained_q.size();

  function automatic int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic int unsigned lin_from_db(int d);
    longint x, n, sh;
    longint unsigned f, pos, idx, r, a, b, v, lin;
    x = (longint'(d) * 43541) >>> 16;
    n = x >>> 16;
    f = x - n * 65536;
    pos = f * EXP_TABLE_DEPTH;
    idx = (pos >> 16) % EXP_TABLE_DEPTH;
    r = pos & 64'hFFFF;
    a = pow2_tab[idx];
    b = (idx + 1 < EXP_TABLE_DEPTH) ? pow2_tab[idx + 1] : 2 * ONE_Q30;
    v = a + (((b - a) * r) >> 16);
    sh = 10 - n;
    if (sh > 40) return 0;
    if (sh < 1) return LIN_MAX;
    lin = (v + (64'd1 << (sh - 1))) >> sh;
    return lin > LIN_MAX ? LIN_MAX : int'(lin);
  endfunction

  function automatic int floor_fine();
    return clampi(int'($signed(r_floor)), -6144, 0) * 256;
  endfunction

  function automatic int active_slots();
    int n;
    n = r_nramp;
    if (n < 1) n = 1;
    if (n > MAX_RAMPERS) n = MAX_RAMPERS;
    return n;
  endfunction

  function automatic void reload_slots();
    int g;
    g = clampi(int'($signed(r_init)), -6144, 1536);
    for (int i = 0; i < MAX_RAMPERS; i++) begin
      gain_cur[i] = g * 256;
      gain_tgt[i] = g;
      gain_step[i] = 0;
      gain_lin[i] = lin_from_db(g * 256);
    end
  endfunction

  function automatic void retarget(int raw);
    int fl, t, tf, cur, diff, s;
    fl = floor_fine() / 256;
    t = clampi(raw, -6144, 1536);
    if (t < fl) t = fl;
    tf = t * 256;
    for (int i = 0; i < active_slots(); i++) begin
      cur = gain_cur[i] < fl * 256 ? fl * 256 : gain_cur[i];
      diff = tf - cur;
      gain_tgt[i] = t;
      if (diff == 0 || r_ramp == 0) begin
        gain_cur[i] = tf;
        gain_step[i] = 0;
        gain_lin[i] = lin_from_db(tf);
      end else begin
        s = diff / int'(r_ramp);
        if (s == 0) s = diff > 0 ? 1 : -1;
        gain_step[i] = s;
      end
    end
  endfunction

  function automatic void advance_ramps();
    int s, tf;
    for (int i = 0; i < active_slots(); i++) begin
      s = gain_step[i];
      tf = gain_tgt[i] * 256;
      if (s != 0) begin
        gain_cur[i] += s;
        if ((s > 0 && gain_cur[i] >= tf) || (s < 0 && gain_cur[i] <= tf)) begin
          gain_cur[i] = tf;
          gain_step[i] = 0;
        end
      end
      if (gain_cur[i] < floor_fine()) gain_cur[i] = floor_fine();
      gain_lin[i] = lin_from_db(gain_cur[i]);
    end
  endfunction

  function automatic gained_t apply_gain(logic [4:0] ch, logic [23:0] smp);
    gained_t res;
    longint s, y;
    int nch, code;
    s = longint'($signed(smp));
    y = s;
    nch = r_nch > MAX_CHANNELS ? MAX_CHANNELS : r_nch;
    if (ch < nch) begin
      code = ch < 16 ? int'((r_map_lo >> (4 * ch)) & 64'hF)
                     : int'((r_map_hi >> (4 * (ch - 16))) & 64'hF);
      if (code != BYPASS_CODE) begin
        if (code >= active_slots()) code = 0;
        y = (s * longint'(gain_lin[code]) + (64'sd1 <<< 19)) >>> 20;
      end
    end
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    res.smp = y[23:0];
    res.chan = ch;
    return res;
  endfunction

  initial begin
    longint unsigned z, term, sum;
    fail_count = 0;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      z = (longint'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * z) >> 30) / k;
        sum += term;
      end
      pow2_tab[i] = sum;
    end
    r_nch = RST_NUM_CHANNELS;
    r_nramp = RST_NUM_RAMPERS;
    r_ramp = RST_RAMP_BLOCKS;
    r_floor = RST_FLOOR_DB;
    r_init = RST_INITIAL_DB;
    r_map_lo = '0;
    r_map_hi = '0;
    reload_slots();
  end

  always @(posedge clk_i) begin
    gained_t want;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_e'(cfg_index))
          CFG_NUM_CHANNELS: r_nch = cfg_data[5:0];
          CFG_NUM_RAMPERS:  r_nramp = cfg_data[3:0];
          CFG_RAMP_BLOCKS:  r_ramp = cfg_data[15:0];
          CFG_FLOOR_DB:     r_floor = cfg_data[13:0];
          CFG_INITIAL_DB: begin
            r_init = cfg_data[13:0];
            reload_slots();
          end
          CFG_MAP_LOW:      r_map_lo = cfg_data;
          CFG_MAP_HIGH:     r_map_hi = cfg_data;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (gained_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected output item: sample %h channel %0d",
                     m_axis_tdata[23:0], m_axis_tdata[28:24]);
        end else begin
          want = gained_q.pop_front();
          if (m_axis_tdata[23:0] !== want.smp || m_axis_tdata[28:24] !== want.chan) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected sample %h channel %0d, got sample %h channel %0d",
                       want.smp, want.chan, m_axis_tdata[23:0], m_axis_tdata[28:24]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (req_e'(s_axis_tuser))
          REQ_SAMPLE: gained_q.push_back(apply_gain(s_axis_tdata[4:0], s_axis_tdata[28:5]));
          REQ_TICK:   advance_ramps();
          REQ_TARGET: retarget(int'($signed(s_axis_tdata[42:29])));
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

>>> sim/multichannel_gain_ramper_core_tb.sv
`default_nettype none
module multichannel_gain_ramper_core_tb;
  import mgr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  int fail_count, pending_count;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  always #10 clk_i = ~clk_i;

  multichannel_gain_ramper_core DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  multichannel_gain_ramper_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending_count
  );

  // The receiver switches among random stall patterns at random times; once asked,
  // it also holds off for one long stretch so the block backs up.
  initial begin
    int mode, mode_left;
    bit held;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_axis_tready = 1'b0;
        repeat (3000) @(negedge clk_i);
        held = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0: m_axis_tready = 1'b1;
        1: m_axis_tready = 1'($urandom_range(0, 1));
        2: m_axis_tready = ($urandom_range(0, 9) == 0);
        default: m_axis_tready = ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] req, logic [4:0] ch, logic [23:0] smp,
                           logic [13:0] tgt);
    if (burst_left == 0) begin
      s_axis_tvalid = 1'b0;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {5'd0, tgt, smp, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [13:0] rand_target();
    if ($urandom_range(0, 7) == 0) return 14'($urandom);
    return 14'($urandom_range(0, 7680)) - 14'd6144;
  endfunction

  initial begin
    int n_items;
    logic [4:0] ch;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part on the reset settings, then with a populated map.
    send_item(REQ_SAMPLE, 5'd0, 24'h7FFFFF, '0);
    send_item(REQ_SAMPLE, 5'd1, 24'h800000, '0);
    send_item(REQ_SAMPLE, 5'd31, 24'h123456, '0);
    send_item(2'd3, 5'd0, 24'h111111, 14'h3FFF);
    write_reg(CFG_NUM_CHANNELS, 64'd63);
    write_reg(CFG_NUM_RAMPERS, 64'd15);
    write_reg(CFG_MAP_LOW, 64'hF0123456789ABCDE);
    write_reg(CFG_MAP_HIGH, 64'h76543210FFFFFFFF);
    write_reg(CFG_RAMP_BLOCKS, 64'd0);
    send_item(REQ_TARGET, '0, '0, 14'sd1536);
    send_item(REQ_SAMPLE, 5'd1, 24'h7FFFFF, '0);
    send_item(REQ_SAMPLE, 5'd0, 24'h800000, '0);
    send_item(REQ_TARGET, '0, '0, 14'h1FFF);
    send_item(REQ_TARGET, '0, '0, 14'h2000);
    send_item(REQ_SAMPLE, 5'd2, 24'h400000, '0);
    write_reg(CFG_FLOOR_DB, 64'd0);
    write_reg(CFG_RAMP_BLOCKS, 64'd3);
    send_item(REQ_TARGET, '0, '0, 14'sd1536);
    repeat (4) send_item(REQ_TICK, '0, '0, '0);
    send_item(REQ_SAMPLE, 5'd20, 24'hFFFFFF, '0);
    send_item(REQ_SAMPLE, 5'd16, 24'h000001, '0);
    write_reg(CFG_RAMP_BLOCKS, 64'd65535);
    send_item(REQ_TARGET, '0, '0, 14'sd1);
    send_item(REQ_TICK, '0, '0, '0);
    send_item(REQ_SAMPLE, 5'd3, 24'h7FFFFF, '0);
    write_reg(CFG_FLOOR_DB, 64'h3FFF & -64'sd6144);
    write_reg(CFG_INITIAL_DB, 64'd1536);
    send_item(REQ_SAMPLE, 5'd5, 24'h7FFFFF, '0);
    write_reg(CFG_INITIAL_DB, 64'h3FFF & -64'sd6144);
    send_item(REQ_SAMPLE, 5'd5, 24'h7FFFFF, '0);

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_NUM_CHANNELS, phase == 0 ? 64'd1 : 64'($urandom_range(0, 63)));
      write_reg(CFG_NUM_RAMPERS, phase == 1 ? 64'd8 : 64'($urandom_range(0, 15)));
      write_reg(CFG_RAMP_BLOCKS, phase == 2 ? 64'd65535 : 64'($urandom_range(0, 20)));
      write_reg(CFG_FLOOR_DB, phase == 3 ? 64'd0 : 64'($urandom & 14'h3FFF));
      write_reg(CFG_INITIAL_DB, 64'($urandom & 14'h3FFF));
      write_reg(CFG_MAP_LOW, {$urandom, $urandom});
      write_reg(CFG_MAP_HIGH, {$urandom, $urandom});
      if (phase == 4) hold_req = 1'b1;
      n_items = 0;
      while (n_items < 125) begin
        if ($urandom_range(0, 9) < 8) begin
          // A ramp: new target, then ticks with samples spread among them.
          send_item(REQ_TARGET, 5'($urandom), 24'($urandom), rand_target());
          n_items++;
          repeat ($urandom_range(1, 25)) begin
            send_item(REQ_TICK, 5'($urandom), 24'($urandom), 14'($urandom));
            repeat ($urandom_range(0, 2)) begin
              ch = 5'($urandom);
              send_item(REQ_SAMPLE, ch, rand_sample(), 14'($urandom));
              n_items++;
            end
            n_items++;
          end
        end else begin
          send_item(2'($urandom), 5'($urandom), 24'($urandom), 14'($urandom));
          n_items++;
        end
      end
      if (phase == 5) drain();
    end

    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
